// ----- sv/echt_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// echt_pkg
// Shared types and constants for the expiring access-code hash table.
// ---------------------------------------------------------------------------
package echt_pkg;

    localparam int CODE_W = 256;
    localparam int EXP_W  = 32;
    localparam int DOOR_W = 16;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [EXP_W-1:0]  expiry_t;
    typedef logic [DOOR_W-1:0] door_t;
    typedef logic [2:0]        status_t;

    // request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // insert outcome codes
    localparam status_t ST_NEW     = 3'd0;
    localparam status_t ST_RAISED  = 3'd1;
    localparam status_t ST_KEPT    = 3'd2;
    localparam status_t ST_IGNORED = 3'd3;
    localparam status_t ST_FULL    = 3'd4;

    localparam door_t DOOR_RESET = 16'd6;

    typedef struct packed {
        logic          req_type;
        door_t         door_id;
        expiry_t       expiration;
        expiry_t       now_secs;
        logic [63:0]   code_word0;
        logic [63:0]   code_word1;
        logic [63:0]   code_word2;
        logic [63:0]   code_word3;
    } req_t;

    typedef struct packed {
        logic    granted;
        status_t insert_status;
    } rsp_t;

    // write strobes from the sequencer to the slot store
    typedef struct packed {
        logic exp_we;
        logic code_we;
    } mem_wr_t;

endpackage

`default_nettype wire

// ----- sv/expiring_code_hash_table_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// expiring_code_hash_table_core
// Linear-probing table of 256-bit access codes with expiry times.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_data): one beat per insert or
//   lookup. cfg channel (cfg_valid/cfg_ready/cfg_data) writes the door id;
//   it is always ready and must only be used while the block is idle.
//   rsp channel (rsp_valid/rsp_ready/rsp_data): one beat per request.
// Sequence:
//   One request at a time. After the request beat, a check step tests the
//   door and expiry of an insert, then each probed slot takes a read step
//   (memory read) and an evaluate step (compare and update in the shared
//   compare unit), then a done step loads the response register. A request
//   probes at most PROBE_LIMIT slots, one at a time through the single
//   slot-store read port; a rejected insert goes from check straight to done.
//   The next request beat is taken only after the done step.
// Reset:
//   After rst_n rises the block sweeps every expiry word to zero, one slot
//   per cycle, with req_ready low. The door register resets to 6.
// Stall:
//   A finished response waits in the output register; the block accepts the
//   next request meanwhile and holds that one's result until rsp is free.
// ---------------------------------------------------------------------------
module expiring_code_hash_table_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int PROBE_LIMIT = 100
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output      logic             cfg_ready,
    input  wire echt_pkg::door_t  cfg_data,
    input  wire logic             req_valid,
    output      logic             req_ready,
    input  wire echt_pkg::req_t   req_data,
    output      logic             rsp_valid,
    input  wire logic             rsp_ready,
    output      echt_pkg::rsp_t   rsp_data
);
    import echt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = $clog2(PROBE_LIMIT + 1);
    localparam logic [AW-1:0] SLOT_LAST  = AW'(TABLE_DEPTH - 1);
    localparam logic [PW-1:0] PROBE_LAST = PW'(PROBE_LIMIT - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_READ,
        S_EVAL,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]   slot_reg, slot_next;
    logic [PW-1:0]   probe_cnt_reg, probe_cnt_next;
    door_t           my_door_reg, my_door_next;
    req_t            req_reg, req_next;
    rsp_t            pend_reg, pend_next;
    rsp_t            rsp_data_reg, rsp_data_next;
    logic            rsp_valid_reg, rsp_valid_next;

    mem_wr_t         mem_wr;
    logic            rd_en;
    logic [AW-1:0]   wr_addr;
    expiry_t         rd_expiry;
    code_t           rd_code;
    code_t           req_code;

    expiry_t         cmp_a;
    expiry_t         cmp_b;
    logic            cmp_lt;
    logic            slot_empty;
    logic            code_match;
    logic            probe_last;
    logic            ins_reject;

    assign req_code = {req_reg.code_word3, req_reg.code_word2,
                       req_reg.code_word1, req_reg.code_word0};

    // slot store
    echt_slot_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr   (slot_reg),
        .wr        (mem_wr),
        .wr_addr   (wr_addr),
        .wr_expiry (state_reg == S_CLEAR ? '0 : req_reg.expiration),
        .wr_code   (req_code),
        .rd_expiry (rd_expiry),
        .rd_code   (rd_code)
    );

    // shared compare unit: operands depend on the sequencer step
    always_comb
    begin
        if (state_reg == S_CHECK)
        begin
            cmp_a = req_reg.expiration;
            cmp_b = req_reg.now_secs;
        end
        else if (req_reg.req_type == REQ_INSERT)
        begin
            cmp_a = rd_expiry;
            cmp_b = req_reg.expiration;
        end
        else
        begin
            cmp_a = req_reg.now_secs;
            cmp_b = rd_expiry;
        end
    end

    assign cmp_lt     = cmp_a < cmp_b;
    assign slot_empty = (rd_expiry == '0);
    assign code_match = (rd_code == req_code);
    assign probe_last = (probe_cnt_reg == PROBE_LAST);
    assign ins_reject = (req_reg.door_id != my_door_reg) || cmp_lt
                        || (req_reg.expiration == '0);
    assign wr_addr    = (state_reg == S_CLEAR) ? clr_cnt_reg : slot_reg;

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        slot_next      = slot_reg;
        probe_cnt_next = probe_cnt_reg;
        my_door_next   = my_door_reg;
        req_next       = req_reg;
        pend_next      = pend_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_valid_next = rsp_valid_reg;
        mem_wr         = '0;
        rd_en          = 1'b0;

        // take a config beat
        if (cfg_valid)
        begin
            my_door_next = cfg_data;
        end

        // drop the response once taken
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_wr.exp_we = 1'b1;
                if (clr_cnt_reg == SLOT_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req_data;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                slot_next      = AW'(req_reg.code_word0[7:0]);
                probe_cnt_next = '0;
                if (req_reg.req_type == REQ_INSERT && ins_reject)
                begin
                    pend_next  = '{granted: 1'b0, insert_status: ST_IGNORED};
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_DONE;
                if (req_reg.req_type == REQ_INSERT)
                begin
                    if (slot_empty)
                    begin
                        mem_wr.exp_we  = 1'b1;
                        mem_wr.code_we = 1'b1;
                        pend_next = '{granted: 1'b0, insert_status: ST_NEW};
                    end
                    else if (code_match)
                    begin
                        if (cmp_lt)
                        begin
                            mem_wr.exp_we = 1'b1;
                            pend_next = '{granted: 1'b0, insert_status: ST_RAISED};
                        end
                        else
                        begin
                            pend_next = '{granted: 1'b0, insert_status: ST_KEPT};
                        end
                    end
                    else if (probe_last)
                    begin
                        pend_next = '{granted: 1'b0, insert_status: ST_FULL};
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
                else
                begin
                    if (slot_empty)
                    begin
                        pend_next = '{granted: 1'b0, insert_status: ST_IGNORED};
                    end
                    else if (code_match)
                    begin
                        pend_next = '{granted: cmp_lt, insert_status: ST_IGNORED};
                    end
                    else if (probe_last)
                    begin
                        pend_next = '{granted: 1'b0, insert_status: ST_IGNORED};
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
                // advance to the next slot, wrapping at the table end
                if (state_next == S_READ)
                begin
                    slot_next      = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_data_next  = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            slot_reg      <= '0;
            probe_cnt_reg <= '0;
            my_door_reg   <= DOOR_RESET;
            req_reg       <= '0;
            pend_reg      <= '0;
            rsp_data_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            slot_reg      <= slot_next;
            probe_cnt_reg <= probe_cnt_next;
            my_door_reg   <= my_door_next;
            req_reg       <= req_next;
            pend_reg      <= pend_next;
            rsp_data_reg  <= rsp_data_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // table writes only during the reset sweep or a probe decision
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr.exp_we || mem_wr.code_we) |-> (state_reg == S_CLEAR || state_reg == S_EVAL))
        else $error("slot store written outside sweep or probe step");

    // a request beat always enters the check step
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_CHECK))
        else $error("request beat did not start a check");

    // probing never runs past the probe limit
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> (probe_cnt_reg <= PROBE_LAST))
        else $error("probe count beyond limit");

    // a grant only comes from a lookup
    a_grant_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.granted) |-> (rsp_data_reg.insert_status == ST_IGNORED))
        else $error("grant reported with an insert status");

endmodule

`default_nettype wire

// ----- sv/echt_slot_mem.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// echt_slot_mem
// Slot store: one expiry word and one 256-bit code row per slot, each with
// one write port and one registered read port.
// ---------------------------------------------------------------------------
module echt_slot_mem #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rd_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
    input  wire echt_pkg::mem_wr_t                 wr,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0]    wr_addr,
    input  wire echt_pkg::expiry_t                 wr_expiry,
    input  wire echt_pkg::code_t                   wr_code,
    output      echt_pkg::expiry_t                 rd_expiry,
    output      echt_pkg::code_t                   rd_code
);
    import echt_pkg::*;

    expiry_t exp_mem  [TABLE_DEPTH];
    code_t   code_mem [TABLE_DEPTH];

    expiry_t rd_expiry_reg;
    code_t   rd_code_reg;

    // expiry array: write, then registered read
    always_ff @(posedge clk)
    begin
        if (wr.exp_we)
        begin
            exp_mem[wr_addr] <= wr_expiry;
        end
        if (rd_en)
        begin
            rd_expiry_reg <= exp_mem[rd_addr];
        end
    end

    // code array: write, then registered read
    always_ff @(posedge clk)
    begin
        if (wr.code_we)
        begin
            code_mem[wr_addr] <= wr_code;
        end
        if (rd_en)
        begin
            rd_code_reg <= code_mem[rd_addr];
        end
    end

    assign rd_expiry = rd_expiry_reg;
    assign rd_code   = rd_code_reg;

endmodule

`default_nettype wire

// ----- tb/expiring_code_hash_table_core_test.sv -----
// ---------------------------------------------------------------------------
// expiring_code_hash_table_core_test
// Self-checking bench for the expiring access-code table. A behavioral copy
// of the table predicts every response at the request beat; a monitor
// compares each response beat with the oldest prediction. Directed cases
// cover the door, expiry and probe boundaries. Random phases then crowd one
// probe region until it is full, mix inserts and lookups of known codes,
// and stall the response side long enough to back up the request side.
// ---------------------------------------------------------------------------
module expiring_code_hash_table_core_test;
    import echt_pkg::*;

    localparam int DEPTH          = 1024;
    localparam int PROBES         = 100;
    localparam int MAX_LATENCY    = 2 + 2 * PROBES;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int CROWD_HOME     = 60;

    logic    clk;
    logic    rst_n;
    logic    cfg_valid;
    logic    cfg_ready;
    door_t   cfg_data;
    logic    req_valid;
    logic    req_ready;
    req_t    req_data;
    logic    rsp_valid;
    logic    rsp_ready;
    rsp_t    rsp_data;

    // shadow copy of the table and the door register
    expiry_t shadow_expiry [DEPTH];
    code_t   shadow_code [DEPTH];
    door_t   door_reg;

    rsp_t    expected_rsp[$];
    code_t   stored_codes[$];
    expiry_t now_s;
    int      errors;
    int      idle_count;
    bit      send_fast;
    bit      sink_fast;
    bit      hold_request;

    expiring_code_hash_table_core #(
        .TABLE_DEPTH(DEPTH),
        .PROBE_LIMIT(PROBES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Probe the shadow table as the block does and apply any update.
    function automatic rsp_t predict_access(req_t r);
        rsp_t  res;
        code_t code;
        int    home;
        int    slot;
        int    i;
        bit    done;
        code = {r.code_word3, r.code_word2, r.code_word1, r.code_word0};
        home = int'(r.code_word0[7:0]) % DEPTH;
        res.granted = 1'b0;
        res.insert_status = ST_IGNORED;
        done = 1'b0;
        if (r.req_type == REQ_INSERT)
        begin
            if (r.door_id == door_reg && r.expiration >= r.now_secs &&
                r.expiration != '0)
            begin
                res.insert_status = ST_FULL;
                for (i = 0; i < PROBES && !done; i++)
                begin
                    slot = (home + i) % DEPTH;
                    if (shadow_expiry[slot] == '0)
                    begin
                        shadow_expiry[slot] = r.expiration;
                        shadow_code[slot] = code;
                        res.insert_status = ST_NEW;
                        stored_codes.push_back(code);
                        done = 1'b1;
                    end
                    else if (shadow_code[slot] == code)
                    begin
                        if (shadow_expiry[slot] < r.expiration)
                        begin
                            shadow_expiry[slot] = r.expiration;
                            res.insert_status = ST_RAISED;
                        end
                        else
                            res.insert_status = ST_KEPT;
                        done = 1'b1;
                    end
                end
            end
        end
        else
        begin
            for (i = 0; i < PROBES && !done; i++)
            begin
                slot = (home + i) % DEPTH;
                if (shadow_expiry[slot] == '0)
                    done = 1'b1;
                else if (shadow_code[slot] == code)
                begin
                    res.granted = (r.now_secs < shadow_expiry[slot]);
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Draw one random request: mostly well formed, partly noise.
    function automatic req_t make_access();
        req_t  r;
        code_t code;
        int    pick;
        now_s = now_s + expiry_t'($urandom_range(0, 3));
        r.req_type = ($urandom_range(0, 1) == 0) ? REQ_INSERT : REQ_LOOKUP;
        code = {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 40 && stored_codes.size() > 0)
            code = stored_codes[$urandom_range(0, stored_codes.size() - 1)];
        else if (pick < 80)
            code[7:0] = 8'(CROWD_HOME + $urandom_range(0, 3));
        r.code_word0 = code[63:0];
        r.code_word1 = code[127:64];
        r.code_word2 = code[191:128];
        r.code_word3 = code[255:192];
        r.door_id = ($urandom_range(0, 99) < 85) ? door_reg : door_t'($urandom);
        r.now_secs = ($urandom_range(0, 9) == 0) ? expiry_t'($urandom) : now_s;
        case ($urandom_range(0, 7))
            0: r.expiration = '0;
            1: r.expiration = r.now_secs;
            2: r.expiration = r.now_secs - 1;
            3: r.expiration = '1;
            4: r.expiration = expiry_t'($urandom);
            default: r.expiration = r.now_secs + expiry_t'($urandom_range(1, 400));
        endcase
        return r;
    endfunction

    // Offer one request beat after a drawn gap and predict it on acceptance.
    task automatic send_access(req_t r);
        int gap;
        gap = send_fast ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_rsp.push_back(predict_access(r));
    endtask

    task automatic send_fields(logic kind, door_t door, expiry_t expiration,
                               expiry_t current, logic [63:0] w0, logic [63:0] w1,
                               logic [63:0] w2, logic [63:0] w3);
        req_t r;
        r.req_type     = kind;
        r.door_id      = door;
        r.expiration   = expiration;
        r.now_secs     = current;
        r.code_word0   = w0;
        r.code_word1   = w1;
        r.code_word2   = w2;
        r.code_word3   = w3;
        send_access(r);
    endtask

    // Drop valid and wait until every predicted response has arrived.
    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_door(door_t d);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        door_reg = d;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Door, expiry and probe boundaries, then the door register extremes.
    // Probe wrap past the top slot cannot occur: homes stop at 255.
    task automatic test_directed_cases();
        logic [63:0] ones;
        ones = '1;
        // code A at home 0: store, keep twice, raise
        send_fields(REQ_INSERT, DOOR_RESET, 32'd100, 32'd50, ones << 8, ones, ones, ones);
        send_fields(REQ_INSERT, DOOR_RESET, 32'd100, 32'd50, ones << 8, ones, ones, ones);
        send_fields(REQ_INSERT, DOOR_RESET, 32'd50, 32'd50, ones << 8, ones, ones, ones);
        send_fields(REQ_INSERT, DOOR_RESET, 32'd200, 32'd50, ones << 8, ones, ones, ones);
        // grant one second before expiry, deny at expiry
        send_fields(REQ_LOOKUP, 16'd0, 32'd0, 32'd199, ones << 8, ones, ones, ones);
        send_fields(REQ_LOOKUP, 16'hFFFF, '1, 32'd200, ones << 8, ones, ones, ones);
        // wrong door, zero expiry, already expired
        send_fields(REQ_INSERT, door_t'(DOOR_RESET + 1), 32'd500, 32'd10, 64'h11,
                    64'd0, 64'd0, 64'd0);
        send_fields(REQ_INSERT, 16'hFFFF, 32'd500, 32'd10, 64'h12, 64'd0, 64'd0, 64'd0);
        send_fields(REQ_INSERT, DOOR_RESET, 32'd0, 32'd0, 64'h13, 64'd0, 64'd0, 64'd0);
        send_fields(REQ_INSERT, DOOR_RESET, 32'd999, 32'd1000, 64'h14, 64'd0, 64'd0, 64'd0);
        // code B at home 255, expiry equal to now, then a lookup finds it expired
        send_fields(REQ_INSERT, DOOR_RESET, '1, '1, 64'hFF, 64'd0, 64'd0, 64'd0);
        send_fields(REQ_LOOKUP, DOOR_RESET, '1, '1, 64'hFF, 64'd0, 64'd0, 64'd0);
        // code C collides with A and lands one slot further
        send_fields(REQ_INSERT, DOOR_RESET, 32'd7000, 32'd0, 64'h100, 64'd1, 64'd2, 64'd3);
        send_fields(REQ_LOOKUP, DOOR_RESET, 32'd0, 32'd0, 64'h100, 64'd1, 64'd2, 64'd3);
        // miss: probe stops at the first empty slot
        send_fields(REQ_LOOKUP, DOOR_RESET, 32'd0, 32'd0, 64'h200, 64'd1, 64'd2, 64'd3);
        send_fields(REQ_LOOKUP, DOOR_RESET, 32'd0, 32'd0, ones << 8, ones, ones, 64'd0);
        // highest door id
        write_door(16'hFFFF);
        send_fields(REQ_INSERT, 16'hFFFF, '1, 32'd0, 64'h55, ones, 64'd0, ones);
        send_fields(REQ_INSERT, DOOR_RESET, '1, 32'd0, 64'h56, ones, 64'd0, ones);
        // lowest door id
        write_door(16'h0000);
        send_fields(REQ_INSERT, 16'h0000, 32'd40, 32'd40, 64'h57, 64'd0, ones, 64'd0);
        send_fields(REQ_LOOKUP, 16'h0000, 32'd0, 32'hFFFF_FFFE, 64'h55, ones, 64'd0, ones);
    endtask

    // Fill the crowded probe region with fresh valid inserts until it overflows.
    task automatic test_crowd_region(int count);
        req_t r;
        code_t code;
        repeat (count)
        begin
            now_s = now_s + 1;
            code = {$urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom};
            code[7:0] = 8'(CROWD_HOME + $urandom_range(0, 3));
            r.req_type     = REQ_INSERT;
            r.door_id      = door_reg;
            r.now_secs     = now_s;
            r.expiration   = now_s + expiry_t'($urandom_range(1, 1000));
            r.code_word0   = code[63:0];
            r.code_word1   = code[127:64];
            r.code_word2   = code[191:128];
            r.code_word3   = code[255:192];
            send_access(r);
        end
    endtask

    task automatic test_random_mix(int count, bit no_idle);
        send_fast = no_idle;
        sink_fast = no_idle;
        repeat (count)
            send_access(make_access());
        send_fast = 1'b0;
        sink_fast = 1'b0;
    endtask

    // Hold the response side off while requests keep coming back to back.
    task automatic test_output_stall(int count);
        hold_request = 1'b1;
        send_fast = 1'b1;
        repeat (count)
            send_access(make_access());
        send_fast = 1'b0;
    endtask

    // Response side: draw a stall per beat, or take a long hold when asked.
    initial
    begin : rsp_sink
        int stall;
        rsp_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
                stall = sink_fast ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Compare each response beat with the oldest prediction.
    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                errors++;
                $display("%0t: response with none pending, granted %0d status %0d",
                         $time, rsp_data.granted, rsp_data.insert_status);
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp_data.granted !== want.granted)
                begin
                    errors++;
                    $display("%0t: granted mismatch, expected %0d, actual %0d",
                             $time, want.granted, rsp_data.granted);
                end
                if (rsp_data.insert_status !== want.insert_status)
                begin
                    errors++;
                    $display("%0t: insert_status mismatch, expected %0d, actual %0d",
                             $time, want.insert_status, rsp_data.insert_status);
                end
            end
        end
    end

    // End the run when no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
            (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, idle_count);
            $display("expiring_code_hash_table_core_test: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        req_valid    = 1'b0;
        req_data     = '0;
        errors       = 0;
        idle_count   = 0;
        send_fast    = 1'b0;
        sink_fast    = 1'b0;
        hold_request = 1'b0;
        door_reg     = DOOR_RESET;
        now_s        = expiry_t'($urandom_range(1000, 1000000));
        foreach (shadow_expiry[i])
            shadow_expiry[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        write_door(DOOR_RESET);
        test_random_mix(100, 1'b0);
        write_door(door_t'($urandom));
        test_crowd_region(120);
        test_random_mix(60, 1'b1);
        write_door(16'h0000);
        test_random_mix(90, 1'b0);
        write_door(16'hFFFF);
        test_random_mix(90, 1'b0);
        write_door(door_t'($urandom));
        test_output_stall(10);
        test_random_mix(60, 1'b0);

        // drain, then watch for stray beats
        wait_idle();
        repeat (MAX_LATENCY) @(posedge clk);
        if (errors == 0)
            $display("expiring_code_hash_table_core_test: clean");
        else
            $display("expiring_code_hash_table_core_test: errors");
        $finish;
    end

endmodule
